/* design/c2dc_pkg.sv */
package c2dc_pkg;

	// Default sizes of the stores
	localparam int DEF_MAX_SIZE_X  = 64;
	localparam int DEF_MAX_SIZE_Y  = 64;
	localparam int DEF_MAX_FILTERS = 16;
	localparam int DEF_FILTER_SIDE = 9;

	// Fixed field widths
	localparam int MODE_W    = 2;
	localparam int COORD_W   = 6;
	localparam int FSEL_W    = 4;
	localparam int TAP_IDX_W = 4;
	localparam int VAL_W     = 16;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int SUM_W     = 39;
	localparam int SIZE_W    = 7;
	localparam int RAD_W     = 3;
	localparam int CFGI_W    = 2;
	localparam int CFGD_W    = 7;
	// Signed working width of a neighbor position (store extent up to 1024)
	localparam int POS_W     = 12;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_TAP  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PIX  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CONV = 2'd2;

	// Register indexes
	localparam logic [CFGI_W-1:0] CFG_SIZE_X = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_SIZE_Y = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_RADIUS = 2'd2;

	typedef struct packed {
		logic                 accept;
		logic                 load;
		logic                 issue;
		logic                 first;
		logic                 last;
		logic [TAP_IDX_W-1:0] col;
		logic [TAP_IDX_W-1:0] row;
	} ctrl_cmd_t;

	typedef struct packed {
		logic                 conv_ok;
		logic                 done;
		logic [TAP_IDX_W-1:0] last_idx;
	} dp_stat_t;

endpackage

/* design/c2dc_ctrl.sv */
module c2dc_ctrl
	import c2dc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd,
	output logic      busy
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]           state_q;
	logic [TAP_IDX_W-1:0] col_q;
	logic [TAP_IDX_W-1:0] row_q;
	logic                 row_end;
	logic                 col_end;

	assign busy    = (state_q != ST_IDLE);
	assign row_end = (row_q == stat.last_idx);
	assign col_end = (col_q == stat.last_idx);

	always_comb begin
		cmd        = '0;
		cmd.accept = start && !busy;
		cmd.load   = cmd.accept && stat.conv_ok;
		cmd.issue  = (state_q == ST_RUN);
		cmd.first  = (col_q == '0) && (row_q == '0);
		cmd.last   = row_end && col_end;
		cmd.col    = col_q;
		cmd.row    = row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						col_q   <= '0;
						row_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// step rows inside columns
					if (row_end) begin
						row_q <= '0;
						if (col_end) begin
							state_q <= ST_DRAIN;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (stat.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/c2dc_dp.sv */
module c2dc_dp
	import c2dc_pkg::*;
#(
	parameter int MAX_SIZE_X  = DEF_MAX_SIZE_X,
	parameter int MAX_SIZE_Y  = DEF_MAX_SIZE_Y,
	parameter int MAX_FILTERS = DEF_MAX_FILTERS,
	parameter int FILTER_SIDE = DEF_FILTER_SIDE
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_cmd_t                cmd,
	output dp_stat_t                 stat,
	input  logic                     cfg_we,
	input  logic [CFGI_W-1:0]        cfg_index,
	input  logic [CFGD_W-1:0]        cfg_data,
	input  logic [MODE_W-1:0]        mode,
	input  logic [COORD_W-1:0]       coord_x,
	input  logic [COORD_W-1:0]       coord_y,
	input  logic [FSEL_W-1:0]        filter_sel,
	input  logic [TAP_IDX_W-1:0]     tap_row,
	input  logic [TAP_IDX_W-1:0]     tap_col,
	input  logic signed [VAL_W-1:0]  value,
	output logic                     result_valid,
	output logic signed [SUM_W-1:0]  conv_sum,
	output logic [COORD_W-1:0]       out_x,
	output logic [COORD_W-1:0]       out_y,
	output logic [FSEL_W-1:0]        out_filter
);

	localparam int IMG_DEPTH = MAX_SIZE_X * MAX_SIZE_Y;
	localparam int FLT_DEPTH = MAX_FILTERS * FILTER_SIDE * FILTER_SIDE;
	localparam int IAW       = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
	localparam int FAW       = (FLT_DEPTH > 1) ? $clog2(FLT_DEPTH) : 1;
	localparam int RMAX      = (FILTER_SIDE - 1) / 2;

	logic signed [VAL_W-1:0] img_mem [IMG_DEPTH];
	logic signed [VAL_W-1:0] flt_mem [FLT_DEPTH];

	logic [SIZE_W-1:0]  size_x_q;
	logic [SIZE_W-1:0]  size_y_q;
	logic [RAD_W-1:0]   radius_q;

	logic [COORD_W-1:0] cx_q;
	logic [COORD_W-1:0] cy_q;
	logic [FSEL_W-1:0]  f_q;
	logic [RAD_W-1:0]   r_q;
	logic [POS_W-1:0]   limx_q;
	logic [POS_W-1:0]   limy_q;

	logic [RAD_W-1:0]   r_eff;
	logic [POS_W-1:0]   limx;
	logic [POS_W-1:0]   limy;

	logic               pix_we;
	logic               tap_we;
	logic [IAW-1:0]     pix_waddr;
	logic [FAW-1:0]     tap_waddr;

	logic [POS_W-1:0]   pxs;
	logic [POS_W-1:0]   pys;
	logic [POS_W-1:0]   px;
	logic [POS_W-1:0]   py;
	logic [IAW-1:0]     iaddr;
	logic [FAW-1:0]     faddr;

	logic               v_s1;
	logic               first_s1;
	logic               last_s1;
	logic [IAW-1:0]     iaddr_s1;
	logic [FAW-1:0]     faddr_s1;

	logic               v_s2;
	logic               first_s2;
	logic               last_s2;
	logic signed [VAL_W-1:0] pix_s2;
	logic signed [VAL_W-1:0] tap_s2;

	logic               v_s3;
	logic               first_s3;
	logic               last_s3;
	logic signed [PROD_W-1:0] prod_s3;

	logic signed [SUM_W-1:0] acc_q;
	logic               result_valid_q;

	// Effective window radius and clamp limits
	always_comb begin
		r_eff = (POS_W'(radius_q) > POS_W'(RMAX)) ? RAD_W'(RMAX) : radius_q;
		if (size_x_q == '0) begin
			limx = '0;
		end else if (POS_W'(size_x_q) > POS_W'(MAX_SIZE_X)) begin
			limx = POS_W'(MAX_SIZE_X - 1);
		end else begin
			limx = POS_W'(size_x_q) - 1'b1;
		end
		if (size_y_q == '0) begin
			limy = '0;
		end else if (POS_W'(size_y_q) > POS_W'(MAX_SIZE_Y)) begin
			limy = POS_W'(MAX_SIZE_Y - 1);
		end else begin
			limy = POS_W'(size_y_q) - 1'b1;
		end
	end

	assign stat.conv_ok  = (mode == MODE_CONV) && (POS_W'(filter_sel) < POS_W'(MAX_FILTERS));
	assign stat.done     = v_s3 && last_s3;
	assign stat.last_idx = {r_q, 1'b0};

	// Write decode; out-of-range writes are dropped
	assign pix_we = cmd.accept && (mode == MODE_PIX)
		&& (POS_W'(coord_x) < POS_W'(MAX_SIZE_X))
		&& (POS_W'(coord_y) < POS_W'(MAX_SIZE_Y));
	assign tap_we = cmd.accept && (mode == MODE_TAP)
		&& (POS_W'(filter_sel) < POS_W'(MAX_FILTERS))
		&& (POS_W'(tap_row) < POS_W'(FILTER_SIDE))
		&& (POS_W'(tap_col) < POS_W'(FILTER_SIDE));
	assign pix_waddr = IAW'(coord_y) * IAW'(MAX_SIZE_X) + IAW'(coord_x);
	assign tap_waddr = (FAW'(filter_sel) * FAW'(FILTER_SIDE) + FAW'(tap_row))
		* FAW'(FILTER_SIDE) + FAW'(tap_col);

	// Neighbor position: center + radius - tap index, clamped to the image edge
	always_comb begin
		pxs = POS_W'(cx_q) + POS_W'(r_q) - POS_W'(cmd.col);
		pys = POS_W'(cy_q) + POS_W'(r_q) - POS_W'(cmd.row);
		if (pxs[POS_W-1]) begin
			px = '0;
		end else if (pxs > limx_q) begin
			px = limx_q;
		end else begin
			px = pxs;
		end
		if (pys[POS_W-1]) begin
			py = '0;
		end else if (pys > limy_q) begin
			py = limy_q;
		end else begin
			py = pys;
		end
		iaddr = IAW'(py) * IAW'(MAX_SIZE_X) + IAW'(px);
		faddr = (FAW'(f_q) * FAW'(FILTER_SIDE) + FAW'(cmd.row))
			* FAW'(FILTER_SIDE) + FAW'(cmd.col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_W'(64);
			size_y_q <= SIZE_W'(64);
			radius_q <= RAD_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SIZE_X: size_x_q <= cfg_data[SIZE_W-1:0];
				CFG_SIZE_Y: size_y_q <= cfg_data[SIZE_W-1:0];
				CFG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Hold the item for the whole window
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q   <= coord_x;
			cy_q   <= coord_y;
			f_q    <= filter_sel;
			r_q    <= r_eff;
			limx_q <= limx;
			limy_q <= limy;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_we) begin
			img_mem[pix_waddr] <= value;
		end
		pix_s2 <= img_mem[iaddr_s1];
	end

	always_ff @(posedge clk) begin
		if (tap_we) begin
			flt_mem[tap_waddr] <= value;
		end
		tap_s2 <= flt_mem[faddr_s1];
	end

	always_ff @(posedge clk) begin
		iaddr_s1 <= iaddr;
		faddr_s1 <= faddr;
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		prod_s3  <= pix_s2 * tap_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			v_s1           <= cmd.issue;
			v_s2           <= v_s1;
			v_s3           <= v_s2;
			result_valid_q <= v_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			acc_q <= (first_s3 ? '0 : acc_q) + {{(SUM_W-PROD_W){prod_s3[PROD_W-1]}}, prod_s3};
		end
	end

	assign result_valid = result_valid_q;
	assign conv_sum     = acc_q;
	assign out_x        = cx_q;
	assign out_y        = cy_q;
	assign out_filter   = f_q;

endmodule

/* design/clamped_2d_convolution_top.sv */
// Pixel and tap writes leave busy low, so the next item may follow at once.
// A compute item walks its (2*radius+1)^2 window, radius capped at (FILTER_SIDE-1)/2, at
// one multiply-accumulate per cycle through one shared multiplier and one read port per store;
// busy drops in the same cycle that result_valid pulses, so no new item is taken before then.
// result_valid is a one-cycle strobe; the receiver cannot stall it.
// Reset clears control and the registers (64, 64, radius 1); both stores stay undefined.
module clamped_2d_convolution_top
	import c2dc_pkg::*;
#(
	parameter int MAX_SIZE_X  = DEF_MAX_SIZE_X,
	parameter int MAX_SIZE_Y  = DEF_MAX_SIZE_Y,
	parameter int MAX_FILTERS = DEF_MAX_FILTERS,
	parameter int FILTER_SIDE = DEF_FILTER_SIDE
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFGI_W-1:0]        cfg_index,
	input  logic [CFGD_W-1:0]        cfg_data,
	input  logic                     start,
	output logic                     busy,
	input  logic [MODE_W-1:0]        mode,
	input  logic [COORD_W-1:0]       coord_x,
	input  logic [COORD_W-1:0]       coord_y,
	input  logic [FSEL_W-1:0]        filter_sel,
	input  logic [TAP_IDX_W-1:0]     tap_row,
	input  logic [TAP_IDX_W-1:0]     tap_col,
	input  logic signed [VAL_W-1:0]  value,
	output logic                     result_valid,
	output logic signed [SUM_W-1:0]  conv_sum,
	output logic [COORD_W-1:0]       out_x,
	output logic [COORD_W-1:0]       out_y,
	output logic [FSEL_W-1:0]        out_filter
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	c2dc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	c2dc_dp #(
		.MAX_SIZE_X  (MAX_SIZE_X),
		.MAX_SIZE_Y  (MAX_SIZE_Y),
		.MAX_FILTERS (MAX_FILTERS),
		.FILTER_SIDE (FILTER_SIDE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.filter_sel   (filter_sel),
		.tap_row      (tap_row),
		.tap_col      (tap_col),
		.value        (value),
		.result_valid (result_valid),
		.conv_sum     (conv_sum),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_filter   (out_filter)
	);

endmodule
